// ===== design/two_link_inverse_kinematics_top_assert.svh =====
// ----------------------------------------------------------------------------
// Two-link IK assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_INVERSE_KINEMATICS_TOP_ASSERT_SVH
`define TWO_LINK_INVERSE_KINEMATICS_TOP_ASSERT_SVH

// same-cycle implication
`define TLIK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLIK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-link IK package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;
  localparam int IT_W             = 5;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LEN  = 2'd3;

  localparam logic [CFG_W-1:0] LEN_RESET = 16'd16;

  localparam int ANG_MAX = 23040;
  // 180 degrees in degrees * 65536
  localparam logic signed [27:0] HALF_TURN = 28'sd11796480;

  typedef struct packed {
    logic [11:0] target_x;
    logic [11:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic               reachable;
    logic signed [15:0] shoulder_angle;
    logic [14:0]        elbow_angle;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] shoulder_x;
    logic [CFG_W-1:0] shoulder_y;
    logic [CFG_W-1:0] upper_len;
    logic [CFG_W-1:0] lower_len;
  } cfg_regs_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_SUM, OP_CHECK, OP_DIV, OP_CSQ, OP_RAD, OP_SQRT,
    OP_KMUL, OP_KSH, OP_PMUL, OP_NUMDEN, OP_E_LOAD, OP_S_LOAD, OP_NORM,
    OP_FLIP, OP_ITER, OP_E_STORE, OP_S_STORE, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reach;
    logic div_last;
    logic sqrt_last;
    logic norm_zero;
    logic norm_ok;
    logic cord_last;
  } dp_sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_SUM, S_CHECK, S_DIV, S_CSQ, S_RAD, S_SQRT, S_KMUL, S_KSH,
    S_PMUL, S_NUMDEN, S_E_LOAD, S_E_NORM, S_E_FLIP, S_E_ITER, S_E_STORE,
    S_S_LOAD, S_S_NORM, S_S_FLIP, S_S_ITER, S_S_STORE, S_DONE
  } ctrl_state_t;

  // atan(2^-i) in degrees * 65536
  function automatic logic [21:0] atan_tab(input logic [IT_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/tlik_ctrl.sv =====
// ----------------------------------------------------------------------------
// Two-link IK controller
// Sequences the datapath through squares, division, square root, products
// and two CORDIC runs, and owns the handshakes.
// ----------------------------------------------------------------------------
`include "two_link_inverse_kinematics_top_assert.svh"

module tlik_ctrl
  import tlik_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t cmd,
  input  dp_sts_t   sts
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.op    = OP_CHECK;
        state_nxt = sts.reach ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_last) state_nxt = S_CSQ;
      end
      S_CSQ: begin
        cmd.op    = OP_CSQ;
        state_nxt = S_RAD;
      end
      S_RAD: begin
        cmd.op    = OP_RAD;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (sts.sqrt_last) state_nxt = S_KMUL;
      end
      S_KMUL: begin
        cmd.op    = OP_KMUL;
        state_nxt = S_KSH;
      end
      S_KSH: begin
        cmd.op    = OP_KSH;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        cmd.op    = OP_PMUL;
        state_nxt = S_NUMDEN;
      end
      S_NUMDEN: begin
        cmd.op    = OP_NUMDEN;
        state_nxt = S_E_LOAD;
      end
      S_E_LOAD: begin
        cmd.op    = OP_E_LOAD;
        state_nxt = S_E_NORM;
      end
      S_E_NORM: begin
        cmd.op = OP_NORM;
        priority if (sts.norm_zero) state_nxt = S_E_STORE;
        else if (sts.norm_ok)       state_nxt = S_E_FLIP;
      end
      S_E_FLIP: begin
        cmd.op    = OP_FLIP;
        state_nxt = S_E_ITER;
      end
      S_E_ITER: begin
        cmd.op = OP_ITER;
        if (sts.cord_last) state_nxt = S_E_STORE;
      end
      S_E_STORE: begin
        cmd.op    = OP_E_STORE;
        state_nxt = S_S_LOAD;
      end
      S_S_LOAD: begin
        cmd.op    = OP_S_LOAD;
        state_nxt = S_S_NORM;
      end
      S_S_NORM: begin
        cmd.op = OP_NORM;
        priority if (sts.norm_zero) state_nxt = S_S_STORE;
        else if (sts.norm_ok)       state_nxt = S_S_FLIP;
      end
      S_S_FLIP: begin
        cmd.op    = OP_FLIP;
        state_nxt = S_S_ITER;
      end
      S_S_ITER: begin
        cmd.op = OP_ITER;
        if (sts.cord_last) state_nxt = S_S_STORE;
      end
      S_S_STORE: begin
        cmd.op    = OP_S_STORE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to drain
        if (out_free) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `TLIK_ASSERT_NXT(a_emit_done, (state_r == S_DONE) && out_free, out_valid_r && (state_r == S_IDLE), "emit did not raise request")
  `TLIK_ASSERT_NOW(a_rise_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "result raised outside done")
  `TLIK_ASSERT_NXT(a_unreach_skip, (state_r == S_CHECK) && !sts.reach, state_r == S_DONE, "unreachable target not skipped")
  `TLIK_ASSERT_NXT(a_div_hold, (state_r == S_DIV) && !sts.div_last, state_r == S_DIV, "divider left early")

endmodule

// ===== design/tlik_dp.sv =====
// ----------------------------------------------------------------------------
// Two-link IK datapath
// Squares, restoring divider, bit-pair square root, link products and a
// shared CORDIC vectoring unit; holds the last solved angles.
// ----------------------------------------------------------------------------
module tlik_dp
  import tlik_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  output dp_sts_t   sts,
  input  in_item_t  in_data,
  input  cfg_regs_t cfg,
  output out_item_t out_data
);

  localparam logic [56:0] ONE56 = 57'd1 << 56;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);

  logic signed [16:0] dx_r, dy_r;
  logic signed [33:0] sqa_r, sqb_r;
  logic [31:0]        l1sq_r, l2sq_r, l12_r;
  logic signed [35:0] n_r;
  logic [32:0]        d_r;
  logic               reach_r, nneg_r;
  logic [34:0]        rem_r;
  logic [28:0]        quo_r;
  logic [IT_W-1:0]    it_r;
  logic [57:0]        csq_r;
  logic [56:0]        v_r, bit_r;
  logic [57:0]        r_r;
  logic [44:0]        lsf_r;
  logic signed [46:0] kcf_r;
  logic [30:0]        ls_r;
  logic signed [32:0] k_r;
  logic signed [49:0] lsdx_r, lsdy_r, kdx_r, kdy_r;
  logic signed [50:0] num_r, den_r;
  logic signed [50:0] cx_r, cy_r;
  logic [50:0]        mg_r;
  logic signed [27:0] cz_r;
  logic signed [15:0] held_sho_r;
  logic [14:0]        held_elb_r;
  out_item_t          out_r;

  logic signed [35:0] d_s, nmag_s;
  logic [34:0]        div_t;
  logic signed [29:0] c_w;
  logic [28:0]        s_w;
  logic [57:0]        rb_w;
  logic signed [46:0] kfull_w;
  logic signed [31:0] ls_s;
  logic signed [50:0] ldx_w, ldy_w;
  logic [50:0]        ax_w, ay_w, m_w;
  logic signed [50:0] shx_w, shy_w;
  logic signed [27:0] tab_w, zr_w;
  logic signed [18:0] q_w;
  logic signed [15:0] sho_w;
  logic [14:0]        elb_w;

  assign d_s    = signed'({3'b000, d_r});
  assign nmag_s = n_r[35] ? -n_r : n_r;
  assign div_t  = (it_r == '0) ? rem_r : {rem_r[33:0], 1'b0};
  assign c_w    = nneg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
  assign s_w    = r_r[28:0];
  assign rb_w   = r_r + {1'b0, bit_r};
  assign kfull_w = signed'({3'b000, cfg.upper_len, 28'd0}) + kcf_r;
  assign ls_s   = signed'({1'b0, ls_r});

  // operands of the next atan2 run and their larger magnitude
  assign ldx_w = (cmd.op == OP_S_LOAD) ? den_r : 51'(c_w);
  assign ldy_w = (cmd.op == OP_S_LOAD) ? num_r : signed'({22'd0, s_w});
  assign ax_w  = ldx_w[50] ? unsigned'(-ldx_w) : unsigned'(ldx_w);
  assign ay_w  = ldy_w[50] ? unsigned'(-ldy_w) : unsigned'(ldy_w);
  assign m_w   = (ax_w > ay_w) ? ax_w : ay_w;
  assign shx_w = cy_r >>> it_r;
  assign shy_w = cx_r >>> it_r;
  assign tab_w = signed'({6'd0, atan_tab(it_r)});

  // round to 1/128 degree, floor, then clamp
  assign zr_w = cz_r + 28'sd256;
  assign q_w  = zr_w[27:9];
  always_comb begin
    priority if (q_w > 19'(ANG_MAX)) sho_w = 16'(ANG_MAX);
    else if (q_w < -19'(ANG_MAX))    sho_w = -16'(ANG_MAX);
    else                             sho_w = q_w[15:0];
    priority if (q_w > 19'(ANG_MAX)) elb_w = 15'(ANG_MAX);
    else if (q_w < 19'sd0)           elb_w = '0;
    else                             elb_w = q_w[14:0];
  end

  assign sts.reach     = (d_r != '0) && (n_r >= -d_s) && (n_r <= d_s);
  assign sts.div_last  = (it_r == IT_W'(28));
  assign sts.sqrt_last = bit_r[0];
  assign sts.norm_zero = (cx_r == '0) && (cy_r == '0);
  assign sts.norm_ok   = (mg_r[50:30] == '0) && mg_r[29];
  assign sts.cord_last = (it_r == IT_LAST);
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_sho_r <= '0;
      held_elb_r <= '0;
      reach_r    <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CHECK:   reach_r    <= sts.reach;
        OP_E_STORE: held_elb_r <= elb_w;
        OP_S_STORE: held_sho_r <= sho_w;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        dx_r <= signed'({1'b0, in_data.target_x, 4'd0}) - signed'({1'b0, cfg.shoulder_x});
        dy_r <= signed'({1'b0, in_data.target_y, 4'd0}) - signed'({1'b0, cfg.shoulder_y});
      end
      OP_SQ: begin
        sqa_r  <= dx_r * dx_r;
        sqb_r  <= dy_r * dy_r;
        l1sq_r <= cfg.upper_len * cfg.upper_len;
        l2sq_r <= cfg.lower_len * cfg.lower_len;
        l12_r  <= cfg.upper_len * cfg.lower_len;
      end
      OP_SUM: begin
        n_r <= 36'(sqa_r) + 36'(sqb_r) - signed'({4'd0, l1sq_r})
               - signed'({4'd0, l2sq_r});
        d_r <= {l12_r, 1'b0};
      end
      OP_CHECK: begin
        rem_r  <= nmag_s[34:0];
        nneg_r <= n_r[35];
        quo_r  <= '0;
        it_r   <= '0;
      end
      OP_DIV: begin
        if (div_t >= {2'b00, d_r}) begin
          rem_r <= div_t - {2'b00, d_r};
          quo_r <= {quo_r[27:0], 1'b1};
        end else begin
          rem_r <= div_t;
          quo_r <= {quo_r[27:0], 1'b0};
        end
        it_r <= it_r + 1'b1;
      end
      OP_CSQ: csq_r <= quo_r * quo_r;
      OP_RAD: begin
        v_r   <= ONE56 - csq_r[56:0];
        r_r   <= '0;
        bit_r <= ONE56;
      end
      OP_SQRT: begin
        if ({1'b0, v_r} >= rb_w) begin
          v_r <= v_r - rb_w[56:0];
          r_r <= (r_r >> 1) + {1'b0, bit_r};
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_KMUL: begin
        lsf_r <= cfg.lower_len * s_w;
        kcf_r <= signed'({1'b0, cfg.lower_len}) * c_w;
      end
      OP_KSH: begin
        ls_r <= lsf_r[44:14];
        k_r  <= kfull_w[46:14];
      end
      OP_PMUL: begin
        lsdx_r <= ls_s * dx_r;
        lsdy_r <= ls_s * dy_r;
        kdx_r  <= k_r * dx_r;
        kdy_r  <= k_r * dy_r;
      end
      OP_NUMDEN: begin
        num_r <= 51'(kdy_r) - 51'(lsdx_r);
        den_r <= 51'(lsdy_r) + 51'(kdx_r);
      end
      OP_E_LOAD: begin
        cx_r <= ldx_w;
        cy_r <= ldy_w;
        mg_r <= m_w;
        cz_r <= '0;
      end
      OP_S_LOAD: begin
        cx_r <= ldx_w;
        cy_r <= ldy_w;
        mg_r <= m_w;
        cz_r <= '0;
      end
      OP_NORM: begin
        // one bit a cycle until the larger magnitude sits in [2^29, 2^30);
        // the magnitude is halved on its own, not re-measured after a floor
        // shift of a negative operand
        if (!sts.norm_zero) begin
          priority if (mg_r[50:30] != '0) begin
            cx_r <= cx_r >>> 1;
            cy_r <= cy_r >>> 1;
            mg_r <= mg_r >> 1;
          end else if (!mg_r[29]) begin
            cx_r <= cx_r <<< 1;
            cy_r <= cy_r <<< 1;
            mg_r <= mg_r << 1;
          end else begin
            cx_r <= cx_r;
          end
        end
      end
      OP_FLIP: begin
        if (cx_r[50]) begin
          cz_r <= cy_r[50] ? -HALF_TURN : HALF_TURN;
          cx_r <= -cx_r;
          cy_r <= -cy_r;
        end
        it_r <= '0;
      end
      OP_ITER: begin
        if (!cy_r[50] && (cy_r != '0)) begin
          cx_r <= cx_r + shx_w;
          cy_r <= cy_r - shy_w;
          cz_r <= cz_r + tab_w;
        end else begin
          cx_r <= cx_r - shx_w;
          cy_r <= cy_r + shy_w;
          cz_r <= cz_r - tab_w;
        end
        it_r <= it_r + 1'b1;
      end
      OP_EMIT: begin
        out_r.reachable      <= reach_r;
        out_r.shoulder_angle <= held_sho_r;
        out_r.elbow_angle    <= held_elb_r;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/two_link_inverse_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// Two-link inverse kinematics
// Solves shoulder and elbow angles of a planar two-bone arm for a target.
// ----------------------------------------------------------------------------
// One target at a time. A reachable target runs through the divider, the
// square root and the shared CORDIC unit, which shifts one bit a cycle into
// range and then runs one rotation per cycle; a zero shoulder direction
// skips its rotations. An unreachable target goes from the reach check
// straight to the result. A stalled result holds the controller only at
// its last step.
// The result register lets the next target be accepted while a result waits.
// Angles are in 1/128 degree; an unreachable target repeats the last angles.
module two_link_inverse_kinematics_top
  import tlik_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_regs_t cfg_r;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shoulder_x <= '0;
      cfg_r.shoulder_y <= '0;
      cfg_r.upper_len  <= LEN_RESET;
      cfg_r.lower_len  <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHOULDER_X: cfg_r.shoulder_x <= cfg_wdata;
        CFG_SHOULDER_Y: cfg_r.shoulder_y <= cfg_wdata;
        CFG_UPPER_LEN:  cfg_r.upper_len  <= cfg_wdata;
        CFG_LOWER_LEN:  cfg_r.lower_len  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tlik_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tlik_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_data (out_data)
  );

endmodule
